// ===== rtl/core/rvat_pkg.sv =====
package rvat_pkg;

   localparam int unsigned MaxSections  = 64;
   localparam int unsigned PageBytes    = 4096;
   localparam int unsigned MinFileAlign = 512;
   localparam int unsigned IdxW         = $clog2(MaxSections);
   localparam int unsigned CountW       = 7;

   localparam logic [2:0] REG_IS_MAPPED     = 3'd0;
   localparam logic [2:0] REG_SIZE_OF_HDRS  = 3'd1;
   localparam logic [2:0] REG_SECT_ALIGN    = 3'd2;
   localparam logic [2:0] REG_FILE_ALIGN    = 3'd3;
   localparam logic [2:0] REG_IMAGE_SIZE    = 3'd4;
   localparam logic [2:0] REG_SECT_COUNT    = 3'd5;

   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   typedef struct packed {
      logic [31:0] rptr;
      logic [31:0] rsize;
      logic [31:0] vsize;
      logic [31:0] va;
   } sect_type;

endpackage

// ===== rtl/core/rva_to_file_offset_translator_top.sv =====
// Translates an image-relative address plus access size into a file offset.
// A transaction with tuser = 0 loads one section table slot and gives no
// result; tuser = 1 translates and always gives one result transaction.
// A load writes its slot and goes no further. A zero address, mapped mode or a
// header-region address goes from idle straight to the output state. Otherwise the
// section table is walked from the last valid entry down to entry 0, and each entry
// visited passes through one table read, three remainder passes over 32-bit
// dividends by the single shared bit-serial divider (section base, rounded raw
// size, raw pointer) and one evaluation step. The block takes one transaction at
// a time; a finished result is held in the output register until taken, and the
// next transaction may be accepted meanwhile.
module rva_to_file_offset_translator_top
   import rvat_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         s_axis_req_tvalid,
   output logic         s_axis_req_tready,
   // [5:0] entry_index, [37:6] entry_virtual_address, [69:38] entry_virtual_size,
   // [101:70] entry_raw_size, [133:102] entry_raw_pointer, [165:134] rva,
   // [197:166] access_size, [199:198] zero
   input  logic [199:0] s_axis_req_tdata,
   // [0] cmd
   input  logic         s_axis_req_tuser,
   output logic         m_axis_rsp_tvalid,
   input  logic         m_axis_rsp_tready,
   // [0] found, [32:1] file_offset, [39:33] zero
   output logic [39:0]  m_axis_rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_VA   = 3'd2;
   localparam logic [2:0] S_RSZ  = 3'd3;
   localparam logic [2:0] S_PTR  = 3'd4;
   localparam logic [2:0] S_EVAL = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // configuration
   logic              mapped_ff;
   logic [31:0]       soh_ff, salign_ff, falign_ff, img_ff;
   logic [CountW-1:0] count_ff;

   // section table, undefined until loaded
   sect_type          mem [MaxSections];
   sect_type          ent_ff;

   logic [2:0]        state_ff, state_in;
   logic [IdxW-1:0]   k_ff, k_in;
   logic [31:0]       rva_ff, rva_in, len_ff, len_in;
   logic [31:0]       base_ff, base_in, rsz_ff, rsz_in, ptr_ff, ptr_in;
   logic [31:0]       dvd_ff, dvd_in;
   logic [31:0]       rem_ff, rem_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              res_found_ff, res_found_in;
   logic [31:0]       res_off_ff, res_off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [31:0]       rsp_off_ff, rsp_off_in;

   logic        req_fire, rd_en;
   logic [5:0]  in_idx;
   sect_type    in_ent;
   logic [31:0] in_rva, in_len;
   logic [31:0] divisor;
   logic [32:0] rem_sh, rem_step;
   logic [31:0] rsz_up;
   logic [CountW-1:0] n_sat;
   logic [31:0] vsz, span, off, sum;
   logic        in_span;
   logic [32:0] hdr_end;

   assign in_idx        = s_axis_req_tdata[5:0];
   assign in_ent.va     = s_axis_req_tdata[37:6];
   assign in_ent.vsize  = s_axis_req_tdata[69:38];
   assign in_ent.rsize  = s_axis_req_tdata[101:70];
   assign in_ent.rptr   = s_axis_req_tdata[133:102];
   assign in_rva        = s_axis_req_tdata[165:134];
   assign in_len        = s_axis_req_tdata[197:166];

   assign s_axis_req_tready = (state_ff == S_IDLE);
   assign req_fire          = s_axis_req_tvalid && s_axis_req_tready;
   assign m_axis_rsp_tvalid = rsp_valid_ff;
   assign m_axis_rsp_tdata  = {7'd0, rsp_off_ff, rsp_found_ff};

   // shared restoring divider step: shift in one dividend bit, subtract if it fits
   assign divisor  = (state_ff == S_VA) ? salign_ff : falign_ff;
   assign rem_sh   = {rem_ff, dvd_ff[31]};
   assign rem_step = (rem_sh >= {1'b0, divisor}) ? rem_sh - {1'b0, divisor} : rem_sh;
   assign rsz_up   = ent_ff.rsize + falign_ff - 32'd1;

   assign n_sat    = (count_ff > CountW'(MaxSections)) ? CountW'(MaxSections) : count_ff;
   assign hdr_end  = {1'b0, in_rva} + {1'b0, in_len};

   assign vsz      = (ent_ff.vsize == 32'd0) ? ent_ff.rsize : ent_ff.vsize;
   assign span     = (vsz > rsz_ff) ? vsz : rsz_ff;
   assign off      = rva_ff - base_ff;
   assign in_span  = (rva_ff >= base_ff) && (off < span);
   assign sum      = ptr_ff + off;
   assign rd_en    = (state_ff == S_READ);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff <= 1'b0;
         soh_ff    <= 32'd0;
         salign_ff <= 32'(PageBytes);
         falign_ff <= 32'(MinFileAlign);
         img_ff    <= 32'd0;
         count_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IS_MAPPED:    mapped_ff <= csr_wdata[0];
            REG_SIZE_OF_HDRS: soh_ff    <= csr_wdata;
            REG_SECT_ALIGN:   salign_ff <= csr_wdata;
            REG_FILE_ALIGN:   falign_ff <= csr_wdata;
            REG_IMAGE_SIZE:   img_ff    <= csr_wdata;
            REG_SECT_COUNT:   count_ff  <= csr_wdata[CountW-1:0];
            default: ;
         endcase
      end
   end

   // section table: one write port; the entry at k_ff is read into ent_ff here, its virtual address into dvd_ff below
   always_ff @(posedge clock) begin
      if (req_fire && (s_axis_req_tuser == CMD_LOAD)) begin
         mem[in_idx[IdxW-1:0]] <= in_ent;
      end
      if (rd_en) begin
         ent_ff <= mem[k_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rva_in       = rva_ff;
      len_in       = len_ff;
      base_in      = base_ff;
      rsz_in       = rsz_ff;
      ptr_in       = ptr_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_found_in = res_found_ff;
      res_off_in   = res_off_ff;
      rsp_valid_in = rsp_valid_ff && !m_axis_rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_off_in   = rsp_off_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (s_axis_req_tuser == CMD_TRANSLATE)) begin
               rva_in       = in_rva;
               len_in       = in_len;
               res_found_in = 1'b0;
               res_off_in   = 32'd0;
               state_in     = S_OUT;
               if (in_rva == 32'd0) begin
                  res_found_in = 1'b0;
               end else if (mapped_ff || (in_rva < soh_ff)) begin
                  // direct map or header region: bounds checks only
                  if ((mapped_ff || (hdr_end <= {1'b0, soh_ff})) &&
                      (in_rva <= img_ff) && (in_len <= img_ff - in_rva)) begin
                     res_found_in = 1'b1;
                     res_off_in   = in_rva;
                  end
               end else if (n_sat != '0) begin
                  k_in     = IdxW'(n_sat - CountW'(1));
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cnt_in   = 5'd0;
            rem_in   = 32'd0;
            state_in = S_VA;
         end
         S_VA, S_RSZ, S_PTR: begin
            rem_in = rem_step[31:0];
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               rem_in = 32'd0;
               cnt_in = 5'd0;
               unique case (state_ff)
                  S_VA: begin
                     base_in  = (salign_ff >= 32'(PageBytes)) ?
                                ent_ff.va - rem_step[31:0] : ent_ff.va;
                     dvd_in   = ent_ff.rsize + falign_ff - 32'd1;
                     state_in = S_RSZ;
                  end
                  S_RSZ: begin
                     rsz_in   = (falign_ff != 32'd0) ? rsz_up - rem_step[31:0] : ent_ff.rsize;
                     dvd_in   = ent_ff.rptr;
                     state_in = S_PTR;
                  end
                  default: begin
                     ptr_in   = (falign_ff >= 32'(MinFileAlign)) ?
                                ent_ff.rptr - rem_step[31:0] : ent_ff.rptr;
                     state_in = S_EVAL;
                  end
               endcase
            end
         end
         S_EVAL: begin
            priority if (in_span && ((off >= rsz_ff) || (len_ff > rsz_ff - off))) begin
               // inside the span but past the raw data: not found
               state_in = S_OUT;
            end else if (!in_span || (~ptr_ff < off)) begin
               // advance to the next lower entry, or stop after entry 0
               if (k_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  k_in     = k_ff - IdxW'(1);
                  state_in = S_READ;
               end
            end else begin
               if ((sum <= img_ff) && (len_ff <= img_ff - sum)) begin
                  res_found_in = 1'b1;
                  res_off_in   = sum;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || m_axis_rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_off_in   = res_off_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // the divider dividend for the section base is taken from the table read
      if (state_ff == S_READ) begin
         dvd_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 5'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      rva_ff       <= rva_in;
      len_ff       <= len_in;
      base_ff      <= base_in;
      rsz_ff       <= rsz_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      res_found_ff <= res_found_in;
      res_off_ff   <= res_off_in;
      rsp_found_ff <= rsp_found_in;
      rsp_off_ff   <= rsp_off_in;
      // the section base pass divides the virtual address just read
      if (state_ff == S_READ) begin
         dvd_ff <= mem[k_ff].va;
      end else begin
         dvd_ff <= dvd_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      s_axis_req_tready |-> (state_ff == S_IDLE))
      else $error("ready outside idle");

   a_zero_rva: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s_axis_req_tuser == CMD_TRANSLATE && in_rva == 32'd0) |=>
      (state_ff == S_OUT && !res_found_ff))
      else $error("zero address not rejected");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside output state");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VA && cnt_ff != 5'd31) |=> (state_ff == S_VA && cnt_ff == $past(cnt_ff) + 5'd1))
      else $error("divider pass broken");

endmodule

// ===== sim/rvat_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and register ports, predicts each translation
// and compares it with the result transaction that comes back.
module rvat_checker
   import rvat_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [199:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           pending,
   output int           xlat_count
);

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
   } xlat_res_type;

   logic         mapped;
   logic [31:0]  hdr_size, sect_align, file_align, img_size;
   logic [6:0]   sect_count;
   sect_type     sections [MaxSections];
   xlat_res_type expected_q [$];

   function automatic bit fits_buf(logic [31:0] o, logic [31:0] n);
      return o <= img_size && n <= img_size - o;
   endfunction

   // Walk the table from the top valid entry down to entry 0.
   function automatic xlat_res_type walk_sections(logic [31:0] addr, logic [31:0] len);
      xlat_res_type r;
      int           n;
      logic [31:0]  base, vsz, rsz, span, off, ptr, sum;
      r = '0;
      n = (sect_count > MaxSections) ? MaxSections : sect_count;
      for (int k = n; k > 0; k--) begin
         base = sections[k-1].va;
         vsz  = sections[k-1].vsize;
         rsz  = sections[k-1].rsize;
         if (sect_align >= PageBytes) base = (base / sect_align) * sect_align;
         if (vsz == 0) vsz = sections[k-1].rsize;
         if (file_align != 0) begin
            sum = rsz + file_align - 32'd1;
            rsz = (sum / file_align) * file_align;
         end
         span = (vsz > rsz) ? vsz : rsz;
         if (addr < base || addr - base >= span) continue;
         off = addr - base;
         if (off >= rsz) return r;
         if (len > rsz - off) return r;
         ptr = sections[k-1].rptr;
         if (file_align >= MinFileAlign) ptr = (ptr / file_align) * file_align;
         if (32'hFFFF_FFFF - ptr < off) continue;
         if (!fits_buf(ptr + off, len)) return r;
         r.found  = 1'b1;
         r.offset = ptr + off;
         return r;
      end
      return r;
   endfunction

   function automatic xlat_res_type predict_offset(logic [31:0] addr, logic [31:0] len);
      xlat_res_type r;
      r = '0;
      if (addr == 0) return r;
      if (mapped || addr < hdr_size) begin
         if (!mapped && ({1'b0, addr} + {1'b0, len}) > {1'b0, hdr_size}) return r;
         if (!fits_buf(addr, len)) return r;
         r.found  = 1'b1;
         r.offset = addr;
         return r;
      end
      return walk_sections(addr, len);
   endfunction

   always @(posedge clock) begin
      xlat_res_type want;
      if (reset) begin
         mapped     = 1'b0;
         hdr_size   = '0;
         sect_align = 32'd4096;
         file_align = 32'd512;
         img_size   = '0;
         sect_count = '0;
         for (int i = 0; i < MaxSections; i++) sections[i] = '0;
         expected_q.delete();
         fail_count = 0;
         xlat_count = 0;
         pending    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IS_MAPPED:    mapped     = csr_wdata[0];
               REG_SIZE_OF_HDRS: hdr_size   = csr_wdata;
               REG_SECT_ALIGN:   sect_align = csr_wdata;
               REG_FILE_ALIGN:   file_align = csr_wdata;
               REG_IMAGE_SIZE:   img_size   = csr_wdata;
               REG_SECT_COUNT:   sect_count = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result transaction: found=%0d file_offset=%h",
                      rsp_tdata[0], rsp_tdata[32:1]);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[0] !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[32:1] !== want.offset) begin
                  $error("file_offset: expected %h, actual %h", want.offset,
                         rsp_tdata[32:1]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_LOAD) begin
               sections[req_tdata[5:0]] = '{rptr: req_tdata[133:102],
                                            rsize: req_tdata[101:70],
                                            vsize: req_tdata[69:38],
                                            va: req_tdata[37:6]};
            end else begin
               expected_q.push_back(predict_offset(req_tdata[165:134],
                                                   req_tdata[197:166]));
               xlat_count++;
            end
         end
         pending = expected_q.size();
      end
   end

endmodule

// ===== sim/tb_rva_to_file_offset_translator_top.sv =====
`timescale 1ns / 100ps

module tb_rva_to_file_offset_translator_top;
   import rvat_pkg::*;

   localparam int StallLimit = 30000;  // watchdog bound, well above a full 64-entry walk

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   int fail_count, pending, xlat_count;
   int stall_cycles;
   bit no_idle;          // long stretch without idling on either side
   int cur_count;        // section count the stimulus aims at
   logic [31:0] slot_va [MaxSections];
   logic [31:0] slot_rs [MaxSections];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rva_to_file_offset_translator_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .s_axis_req_tvalid (req_tvalid),
      .s_axis_req_tready (req_tready),
      .s_axis_req_tdata  (req_tdata),
      .s_axis_req_tuser  (req_tuser),
      .m_axis_rsp_tvalid (rsp_tvalid),
      .m_axis_rsp_tready (rsp_tready),
      .m_axis_rsp_tdata  (rsp_tdata),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   rvat_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .xlat_count (xlat_count)
   );

   // Result side: stall with a chance of about 18 percent, unless no_idle is set.
   always @(posedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 18);

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("watchdog: no transaction for %0d cycles", StallLimit);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Present one transaction and hold it until taken; idle first at random.
   task automatic send_req(logic cmd, logic [199:0] data);
      if (!no_idle && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_slot(logic [5:0] idx, logic [31:0] va, logic [31:0] vs,
                            logic [31:0] rs, logic [31:0] rp);
      slot_va[idx] = va;
      slot_rs[idx] = rs;
      send_req(CMD_LOAD, {2'b0, $urandom(), $urandom(), rp, rs, vs, va, idx});
   endtask

   // Junk in the unused entry fields keeps them toggling; the top two bits stay zero.
   task automatic translate(logic [31:0] addr, logic [31:0] len);
      send_req(CMD_TRANSLATE, {2'b0, len, addr, $urandom(), $urandom(),
                               $urandom(), $urandom(), 6'($urandom())});
   endtask

   // Drop valid and wait until every result has come back and loads settle.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_regs(logic mp, logic [31:0] hdr, logic [31:0] sa,
                             logic [31:0] fa, logic [31:0] img, logic [6:0] cnt);
      logic [31:0] vals [6];
      vals = '{{31'b0, mp}, hdr, sa, fa, img, {25'b0, cnt}};
      drain();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_count = (cnt > MaxSections) ? MaxSections : cnt;
   endtask

   function automatic logic [31:0] pick_len();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom();
         default: return $urandom_range(64);
      endcase
   endfunction

   // Aim mostly at the loaded sections, near their edges now and then.
   function automatic logic [31:0] pick_rva();
      int s;
      if (cur_count == 0 || $urandom_range(9) == 0) return $urandom();
      s = $urandom_range(cur_count - 1);
      case ($urandom_range(4))
         0:       return slot_va[s];
         1:       return slot_va[s] + slot_rs[s] - $urandom_range(3);
         2:       return slot_va[s] + slot_rs[s] + $urandom_range(600);
         default: return slot_va[s] + $urandom_range(slot_rs[s]);
      endcase
   endfunction

   task automatic random_load;
      logic [31:0] va, vs, rs, rp;
      va = ($urandom_range(3) == 0) ? $urandom() : ($urandom() & 32'h3FFF_F000);
      vs = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(32'h3000);
      rs = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(32'h2400);
      rp = ($urandom_range(5) == 0) ? (32'hFFFF_FFFF - $urandom_range(32'h800))
                                    : $urandom_range(32'h00FF_FFFF);
      load_slot(6'($urandom_range(MaxSections - 1)), va, vs, rs, rp);
   endtask

   initial begin
      logic [31:0] sa_pick [4];
      logic [31:0] fa_pick [5];
      int          n_items;
      sa_pick = '{32'd0, 32'd4096, 32'h0001_0000, 32'hFFFF_FFFF};
      fa_pick = '{32'd0, 32'd1, 32'd512, 32'd4096, 32'hFFFF_FFFF};
      no_idle = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Fill every slot so no walk ever reads an unwritten entry.
      write_regs(1'b0, 32'h400, 32'd4096, 32'd512, 32'h0100_0000, 7'd8);
      for (int i = 0; i < MaxSections; i++)
         load_slot(6'(i), 32'h1000 + 32'(i) * 32'h2000, 32'h1800,
                   32'h1000 + 32'(i) * 32'h10, 32'h400 + 32'(i) * 32'h2000);

      // Directed: zero address, header region, overflow past headers, sections.
      translate(32'd0, 32'd4);
      translate(32'h10, 32'h10);
      translate(32'h3F0, 32'h20);
      translate(32'h3FF, 32'hFFFF_FFFF);
      translate(32'h1000, 32'd0);
      translate(32'h1004, 32'd16);
      translate(32'h2100, 32'd4);       // past raw size, inside virtual span
      translate(32'h1FFF_0000, 32'd4);  // no section holds it
      translate(32'hFFFF_FFFF, 32'd1);
      // Raw pointer that would pass 2^32-1: the walk moves to a lower entry.
      load_slot(6'd7, 32'h3000, 32'd0, 32'h1000, 32'hFFFF_FF00);
      translate(32'h3800, 32'd4);
      translate(32'h3000, 32'd8);       // zero virtual size uses raw size

      write_regs(1'b1, 32'h400, 32'd4096, 32'd512, 32'hFFFF_FFFF, 7'd0);
      translate(32'hFFFF_FFFF, 32'd0);
      translate(32'hFFFF_FFFF, 32'd1);
      translate(32'h1234, 32'hFFFF_FFFF);
      write_regs(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 7'd0);
      translate(32'h5000, 32'd0);
      translate(32'h5000, 32'd1);
      write_regs(1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0);
      translate(32'h5000, 32'd4);       // zero section count
      write_regs(1'b0, 32'd0, 32'd4096, 32'd512, 32'hFFFF_FFFF, 7'd127);
      translate(32'h1004, 32'd4);       // count saturates, walk reaches entry 0
      translate(32'h7F000, 32'd4);

      // Random phases: small tables mostly, one full-table phase kept short.
      for (int p = 0; p < 12; p++) begin
         no_idle = (p == 4 || p == 5);
         write_regs($urandom_range(4) == 0,
                    ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(32'h1000),
                    sa_pick[$urandom_range(3)], fa_pick[$urandom_range(4)],
                    ($urandom_range(3) == 0) ? $urandom() : 32'h0200_0000,
                    (p == 7) ? 7'd64 : 7'($urandom_range(1, 8)));
         n_items = (p == 7) ? 6 : 45;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(3) == 0 && p != 7)
               random_load();
            else
               translate(pick_rva(), pick_len());
         end
      end
      no_idle = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d translations over 17 register settings,", xlat_count);
      $display("mapped, header, section walk and saturated-count cases");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
